@@ design/sbma_pkg.sv @@
// ----------------------------------------------------------------------------
// Sparse block matrix assembler package
// Shared widths, codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package sbma_pkg;

  localparam int unsigned MaxBlocksDef = 256;
  localparam int unsigned BlockLenDef  = 2;
  localparam int unsigned MaxRowsDef   = 64;

  localparam int unsigned KIND_W    = 3;
  localparam int unsigned ROW_W     = 6;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned EL_W      = 2;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned POS_W     = 9;
  localparam int unsigned ST_W      = 3;
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned NR_W      = 7;
  localparam int unsigned NC_W      = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned KEY_W     = ROW_W + COL_W;

  localparam logic [NR_W-1:0] NumRowsRst = NR_W'(64);
  localparam logic [NC_W-1:0] NumColsRst = NC_W'(1024);

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR      = 3'd0,
    KIND_LOAD       = 3'd1,
    KIND_BUILD      = 3'd2,
    KIND_READ_ENTRY = 3'd3,
    KIND_READ_ROW   = 3'd4,
    KIND_FIND       = 3'd5
  } kind_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_RANGE     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NOT_BUILT = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ROWS = 2'd0,
    CFG_NUM_COLS = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_ENTRY,
    SRC_ROW_START,
    SRC_FOUND
  } res_src_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LZERO,
    S_BMIN,
    S_BSUM,
    S_BPK,
    S_BRS,
    S_BTAIL,
    S_RDENT,
    S_RDRS,
    S_FLO,
    S_FHI,
    S_FSCAN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic     cap_in;
    logic     ld_clear;
    logic     ld_wr_row;
    logic     ld_wr_zero;
    logic     ld_wr_el;
    logic     ld_inc;
    logic     k_clr;
    logic     k_inc;
    logic     bld_init;
    logic     scan_start;
    logic     scan_sum;
    logic     scan_issue;
    logic     take_min;
    logic     pk_wr;
    logic     rs_wr;
    logic     cnt_inc;
    logic     built_set;
    logic     rd_entry;
    logic     rd_rs_pos;
    logic     rd_rs_ri;
    logic     rd_rs_ri1;
    logic     f_lo;
    logic     f_hi;
    logic     f_issue;
    logic     res_load;
    status_e  res_status;
    res_src_e res_src;
    logic     push;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic el_bad;
    logic el_zero;
    logic range_bad;
    logic full;
    logic empty;
    logic built;
    logic pos_bad_entry;
    logic pos_bad_rs;
    logic k_last;
    logic issue_done;
    logic s1_valid;
    logic min_found;
    logic rs_more;
    logic rs_tail_more;
    logic f_issue_done;
    logic f_hit;
    logic out_free;
  } sts_t;

endpackage

@@ design/sbma_if.sv @@
// ----------------------------------------------------------------------------
// Sparse block matrix assembler channels
// Command, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface sbma_in_if import sbma_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ROW_W-1:0]    row_index;
  logic [COL_W-1:0]    col_index;
  logic [EL_W-1:0]     element;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]    position;

  modport source (output valid, kind, row_index, col_index, element, value, position,
                  input ready);
  modport sink   (input valid, kind, row_index, col_index, element, value, position,
                  output ready);
endinterface

interface sbma_out_if import sbma_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [ST_W-1:0]     status;
  logic [ROW_W-1:0]    out_row;
  logic [COL_W-1:0]    out_col;
  logic signed [VAL_W-1:0] out_value;
  logic [IDX_W-1:0]    out_index;
  logic [IDX_W-1:0]    block_count;

  modport source (output valid, status, out_row, out_col, out_value, out_index,
                  block_count, input ready);
  modport sink   (input valid, status, out_row, out_col, out_value, out_index,
                  block_count, output ready);
endinterface

interface sbma_cfg_if import sbma_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [NC_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/sbma_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sparse block matrix assembler controller
// Sequences each command word through the datapath by command and status.
// ----------------------------------------------------------------------------
module sbma_ctrl import sbma_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.res_status = ST_OK;
        cmd_o.res_src    = SRC_NONE;
        state_d          = S_RESP;
        unique case (sts_i.kind)
          KIND_CLEAR: begin
            cmd_o.ld_clear = 1'b1;
            cmd_o.res_load = 1'b1;
          end
          KIND_LOAD: begin
            cmd_o.res_load = 1'b1;
            if (sts_i.el_bad) begin
              cmd_o.res_status = ST_RANGE;
            end else if (sts_i.el_zero) begin
              if (sts_i.range_bad) begin
                cmd_o.res_status = ST_RANGE;
              end else if (sts_i.full) begin
                cmd_o.res_status = ST_FULL;
              end else begin
                cmd_o.res_load  = 1'b0;
                cmd_o.ld_wr_row = 1'b1;
                cmd_o.k_clr     = 1'b1;
                state_d         = S_LZERO;
              end
            end else if (sts_i.empty) begin
              cmd_o.res_status = ST_RANGE;
            end else begin
              cmd_o.ld_wr_el = 1'b1;
            end
          end
          KIND_BUILD: begin
            cmd_o.bld_init   = 1'b1;
            cmd_o.scan_start = 1'b1;
            state_d          = S_BMIN;
          end
          KIND_READ_ENTRY: begin
            if (!sts_i.built) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_NOT_BUILT;
            end else if (sts_i.pos_bad_entry) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_RANGE;
            end else begin
              cmd_o.rd_entry = 1'b1;
              state_d        = S_RDENT;
            end
          end
          KIND_READ_ROW: begin
            if (!sts_i.built) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_NOT_BUILT;
            end else if (sts_i.pos_bad_rs) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_RANGE;
            end else begin
              cmd_o.rd_rs_pos = 1'b1;
              state_d         = S_RDRS;
            end
          end
          KIND_FIND: begin
            if (!sts_i.built) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_NOT_BUILT;
            end else if (sts_i.range_bad) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_RANGE;
            end else begin
              cmd_o.rd_rs_ri = 1'b1;
              state_d        = S_FLO;
            end
          end
          default: begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_RANGE;
          end
        endcase
      end
      S_LZERO: begin
        cmd_o.ld_wr_zero = 1'b1;
        cmd_o.k_inc      = 1'b1;
        if (sts_i.k_last) begin
          cmd_o.ld_inc     = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OK;
          cmd_o.res_src    = SRC_NONE;
          state_d          = S_RESP;
        end
      end
      S_BMIN: begin
        cmd_o.scan_issue = !sts_i.issue_done;
        if (sts_i.issue_done && !sts_i.s1_valid) begin
          if (sts_i.min_found) begin
            cmd_o.take_min   = 1'b1;
            cmd_o.scan_start = 1'b1;
            state_d          = S_BSUM;
          end else begin
            state_d = S_BTAIL;
          end
        end
      end
      S_BSUM: begin
        cmd_o.scan_sum   = 1'b1;
        cmd_o.scan_issue = !sts_i.issue_done;
        if (sts_i.issue_done && !sts_i.s1_valid) begin
          cmd_o.k_clr = 1'b1;
          state_d     = S_BPK;
        end
      end
      S_BPK: begin
        cmd_o.pk_wr = 1'b1;
        cmd_o.k_inc = 1'b1;
        if (sts_i.k_last) begin
          state_d = S_BRS;
        end
      end
      S_BRS: begin
        if (sts_i.rs_more) begin
          cmd_o.rs_wr = 1'b1;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          if (sts_i.min_found) begin
            cmd_o.take_min   = 1'b1;
            cmd_o.scan_start = 1'b1;
            state_d          = S_BSUM;
          end else begin
            state_d = S_BTAIL;
          end
        end
      end
      S_BTAIL: begin
        if (sts_i.rs_tail_more) begin
          cmd_o.rs_wr = 1'b1;
        end else begin
          cmd_o.built_set  = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OK;
          cmd_o.res_src    = SRC_NONE;
          state_d          = S_RESP;
        end
      end
      S_RDENT: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = ST_OK;
        cmd_o.res_src    = SRC_ENTRY;
        state_d          = S_RESP;
      end
      S_RDRS: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = ST_OK;
        cmd_o.res_src    = SRC_ROW_START;
        state_d          = S_RESP;
      end
      S_FLO: begin
        cmd_o.f_lo      = 1'b1;
        cmd_o.rd_rs_ri1 = 1'b1;
        state_d         = S_FHI;
      end
      S_FHI: begin
        cmd_o.f_hi = 1'b1;
        state_d    = S_FSCAN;
      end
      S_FSCAN: begin
        if (sts_i.f_hit) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OK;
          cmd_o.res_src    = SRC_FOUND;
          state_d          = S_RESP;
        end else if (sts_i.f_issue_done && !sts_i.s1_valid) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NOT_FOUND;
          cmd_o.res_src    = SRC_NONE;
          state_d          = S_RESP;
        end else begin
          cmd_o.f_issue = !sts_i.f_issue_done;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/sbma_dp.sv @@
// ----------------------------------------------------------------------------
// Sparse block matrix assembler datapath
// Load and packed stores, build scan with lane accumulators, result registers.
// ----------------------------------------------------------------------------
module sbma_dp import sbma_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MaxBlocksDef,
  parameter int unsigned BLOCK_LEN  = BlockLenDef,
  parameter int unsigned MAX_ROWS   = MaxRowsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [KIND_W-1:0]       kind_i,
  input  logic [ROW_W-1:0]        row_index_i,
  input  logic [COL_W-1:0]        col_index_i,
  input  logic [EL_W-1:0]         element_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic                    cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [NC_W-1:0]         cfg_data_i,
  output logic                    cfg_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ST_W-1:0]         status_o,
  output logic [ROW_W-1:0]        out_row_o,
  output logic [COL_W-1:0]        out_col_o,
  output logic signed [VAL_W-1:0] out_value_o,
  output logic [IDX_W-1:0]        out_index_o,
  output logic [IDX_W-1:0]        block_count_o,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o
);

  localparam int unsigned BSZ  = BLOCK_LEN * BLOCK_LEN;
  localparam int unsigned KW   = (BSZ > 1) ? $clog2(BSZ) : 1;
  localparam int unsigned LCW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned LAW  = $clog2(MAX_BLOCKS);
  localparam int unsigned VD   = MAX_BLOCKS * BSZ;
  localparam int unsigned VAW  = $clog2(VD);
  localparam int unsigned VCW  = $clog2(VD + 1);
  localparam int unsigned RSD  = MAX_ROWS + 1;
  localparam int unsigned RSAW = $clog2(RSD);
  localparam int unsigned NRW  = $clog2(MAX_ROWS + 2);

  // Configuration
  logic [NR_W-1:0] nr_q;
  logic [NC_W-1:0] nc_q;

  // Captured command word
  logic [KIND_W-1:0] kind_q;
  logic [ROW_W-1:0]  ri_q;
  logic [COL_W-1:0]  ci_q;
  logic [EL_W-1:0]   el_q;
  logic [VAL_W-1:0]  val_q;
  logic [POS_W-1:0]  pos_q;

  // Counters
  logic [LCW-1:0] lcnt_q, cnt_q, t_q, p_q, hi_q, s1_p_q;
  logic [VCW-1:0] lbase_q, pbase_q, va_q;
  logic [NRW-1:0] next_row_q;
  logic [KW-1:0]  bk_q, s1_k_q;
  logic           built_q, s1_valid_q, min_found_q;
  logic [KEY_W-1:0] min_q, cur_q;
  logic [VAL_W-1:0] acc_q [BSZ];

  // Stores
  logic [ROW_W-1:0] loaded_row   [MAX_BLOCKS];
  logic [COL_W-1:0] loaded_col   [MAX_BLOCKS];
  logic [VAL_W-1:0] loaded_value [VD];
  logic [ROW_W-1:0] packed_row   [MAX_BLOCKS];
  logic [COL_W-1:0] packed_col   [MAX_BLOCKS];
  logic [VAL_W-1:0] packed_value [VD];
  logic [LCW-1:0]   row_start    [RSD];

  logic [ROW_W-1:0] lrow_rd_q, prow_rd_q;
  logic [COL_W-1:0] lcol_rd_q, pcol_rd_q;
  logic [VAL_W-1:0] lval_rd_q, pval_rd_q;
  logic [LCW-1:0]   rs_rd_q;

  // Result and output registers
  logic [ST_W-1:0]  res_st_q;
  logic [ROW_W-1:0] res_row_q;
  logic [COL_W-1:0] res_col_q;
  logic [VAL_W-1:0] res_val_q;
  logic [IDX_W-1:0] res_idx_q;
  logic             out_valid_q;
  logic [ST_W-1:0]  out_st_q;
  logic [ROW_W-1:0] out_row_q;
  logic [COL_W-1:0] out_col_q;
  logic [VAL_W-1:0] out_val_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [IDX_W-1:0] out_cnt_q;

  logic             k_last, out_free, s1_in_rng, s1_hit, s1_new_min;
  logic [KEY_W-1:0] s1_key;
  logic [KW-1:0]    acc_idx;
  logic [VAL_W-1:0] acc_rd;
  logic [VAW-1:0]   lv_waddr, pv_raddr;
  logic [VAL_W-1:0] lv_wdata;
  logic             lv_we;
  logic [RSAW-1:0]  rs_raddr;
  logic [LAW-1:0]   pc_raddr;

  assign k_last   = (bk_q == KW'(BSZ - 1));
  assign out_free = !out_valid_q || out_ready_i;

  assign s1_key    = {lrow_rd_q, lcol_rd_q};
  assign s1_in_rng = (32'(lrow_rd_q) < 32'(nr_q)) && (32'(lrow_rd_q) < MAX_ROWS) &&
                     (32'(lcol_rd_q) < 32'(nc_q));
  assign s1_hit    = s1_valid_q && cmd_i.scan_sum && s1_in_rng && (s1_key == cur_q);
  assign s1_new_min = s1_valid_q && s1_in_rng && (s1_k_q == '0) &&
                      (!cmd_i.scan_sum || (s1_key > cur_q)) &&
                      (!min_found_q || (s1_key < min_q));

  // One lane read port shared by the summing pass and the packed write-out.
  assign acc_idx = cmd_i.pk_wr ? bk_q : s1_k_q;
  assign acc_rd  = acc_q[acc_idx];

  assign lv_we    = cmd_i.ld_wr_zero || cmd_i.ld_wr_el;
  assign lv_waddr = cmd_i.ld_wr_el ? VAW'(32'(lbase_q) - BSZ + 32'(el_q))
                                   : VAW'(32'(lbase_q) + 32'(bk_q));
  assign lv_wdata = (cmd_i.ld_wr_el || (bk_q == '0)) ? val_q : '0;
  assign pv_raddr = VAW'(32'(pos_q) * BSZ + 32'(el_q));
  assign pc_raddr = cmd_i.f_issue ? p_q[LAW-1:0] : LAW'(pos_q);

  always_comb begin
    if (cmd_i.rd_rs_ri) begin
      rs_raddr = RSAW'(ri_q);
    end else if (cmd_i.rd_rs_ri1) begin
      rs_raddr = RSAW'(32'(ri_q) + 32'd1);
    end else begin
      rs_raddr = RSAW'(pos_q);
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.kind          = kind_q;
    sts_o.el_bad        = 32'(el_q) >= BSZ;
    sts_o.el_zero       = (el_q == '0);
    sts_o.range_bad     = !((32'(ri_q) < 32'(nr_q)) && (32'(ri_q) < MAX_ROWS)) ||
                          (32'(ci_q) >= 32'(nc_q));
    sts_o.full          = 32'(lcnt_q) >= MAX_BLOCKS;
    sts_o.empty         = (lcnt_q == '0);
    sts_o.built         = built_q;
    sts_o.pos_bad_entry = (32'(pos_q) >= 32'(cnt_q)) || (32'(el_q) >= BSZ);
    sts_o.pos_bad_rs    = 32'(pos_q) > MAX_ROWS;
    sts_o.k_last        = k_last;
    sts_o.issue_done    = (t_q == lcnt_q);
    sts_o.s1_valid      = s1_valid_q;
    sts_o.min_found     = min_found_q;
    sts_o.rs_more       = 32'(next_row_q) <= 32'(cur_q[KEY_W-1 -: ROW_W]);
    sts_o.rs_tail_more  = 32'(next_row_q) <= MAX_ROWS;
    sts_o.f_issue_done  = 32'(p_q) >= 32'(hi_q);
    sts_o.f_hit         = s1_valid_q && (pcol_rd_q == ci_q);
    sts_o.out_free      = out_free;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nr_q        <= NumRowsRst;
      nc_q        <= NumColsRst;
      lcnt_q      <= '0;
      lbase_q     <= '0;
      cnt_q       <= '0;
      pbase_q     <= '0;
      next_row_q  <= '0;
      built_q     <= 1'b0;
      bk_q        <= '0;
      t_q         <= '0;
      va_q        <= '0;
      s1_valid_q  <= 1'b0;
      min_found_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_NUM_ROWS: nr_q <= cfg_data_i[NR_W-1:0];
          CFG_NUM_COLS: nc_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.ld_clear) begin
        lcnt_q  <= '0;
        lbase_q <= '0;
      end else if (cmd_i.ld_inc) begin
        lcnt_q  <= lcnt_q + 1'b1;
        lbase_q <= VCW'(32'(lbase_q) + BSZ);
      end
      if (cmd_i.bld_init) begin
        cnt_q      <= '0;
        pbase_q    <= '0;
        next_row_q <= '0;
      end else begin
        if (cmd_i.cnt_inc) begin
          cnt_q   <= cnt_q + 1'b1;
          pbase_q <= VCW'(32'(pbase_q) + BSZ);
        end
        if (cmd_i.rs_wr) begin
          next_row_q <= next_row_q + 1'b1;
        end
      end
      if (cmd_i.built_set) begin
        built_q <= 1'b1;
      end
      if (cmd_i.k_clr || cmd_i.scan_start) begin
        bk_q <= '0;
      end else if (cmd_i.k_inc || cmd_i.scan_issue) begin
        bk_q <= k_last ? '0 : bk_q + 1'b1;
      end
      if (cmd_i.scan_start) begin
        t_q  <= '0;
        va_q <= '0;
      end else if (cmd_i.scan_issue) begin
        va_q <= va_q + 1'b1;
        if (k_last) begin
          t_q <= t_q + 1'b1;
        end
      end
      s1_valid_q <= cmd_i.scan_issue || cmd_i.f_issue;
      if (cmd_i.scan_start) begin
        min_found_q <= 1'b0;
      end else if (s1_new_min) begin
        min_found_q <= 1'b1;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      kind_q <= kind_i;
      ri_q   <= row_index_i;
      ci_q   <= col_index_i;
      el_q   <= element_i;
      val_q  <= value_i;
      pos_q  <= position_i;
    end
    s1_k_q <= bk_q;
    s1_p_q <= p_q;
    if (s1_new_min) begin
      min_q <= s1_key;
    end
    if (cmd_i.take_min) begin
      cur_q <= min_q;
    end
    if (cmd_i.scan_start) begin
      for (int i = 0; i < BSZ; i++) begin
        acc_q[i] <= '0;
      end
    end else if (s1_hit) begin
      acc_q[acc_idx] <= acc_rd + lval_rd_q;
    end
    if (cmd_i.f_lo) begin
      p_q <= rs_rd_q;
    end else if (cmd_i.f_issue) begin
      p_q <= p_q + 1'b1;
    end
    if (cmd_i.f_hi) begin
      hi_q <= rs_rd_q;
    end
    if (cmd_i.res_load) begin
      res_st_q  <= cmd_i.res_status;
      res_row_q <= '0;
      res_col_q <= '0;
      res_val_q <= '0;
      res_idx_q <= '0;
      case (cmd_i.res_src)
        SRC_ENTRY: begin
          res_row_q <= prow_rd_q;
          res_col_q <= pcol_rd_q;
          res_val_q <= pval_rd_q;
          res_idx_q <= pos_q;
        end
        SRC_ROW_START: res_idx_q <= IDX_W'(rs_rd_q);
        SRC_FOUND:     res_idx_q <= IDX_W'(s1_p_q);
        default: ;
      endcase
    end
    if (cmd_i.push) begin
      out_st_q  <= res_st_q;
      out_row_q <= res_row_q;
      out_col_q <= res_col_q;
      out_val_q <= res_val_q;
      out_idx_q <= res_idx_q;
      out_cnt_q <= built_q ? IDX_W'(cnt_q) : '0;
    end
  end

  // Load stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_wr_row) begin
      loaded_row[lcnt_q[LAW-1:0]] <= ri_q;
      loaded_col[lcnt_q[LAW-1:0]] <= ci_q;
    end
    lrow_rd_q <= loaded_row[t_q[LAW-1:0]];
    lcol_rd_q <= loaded_col[t_q[LAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (lv_we) begin
      loaded_value[lv_waddr] <= lv_wdata;
    end
    lval_rd_q <= loaded_value[va_q[VAW-1:0]];
  end

  // Packed stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.pk_wr && (bk_q == '0)) begin
      packed_row[cnt_q[LAW-1:0]] <= cur_q[KEY_W-1 -: ROW_W];
      packed_col[cnt_q[LAW-1:0]] <= cur_q[COL_W-1:0];
    end
    prow_rd_q <= packed_row[pc_raddr];
    pcol_rd_q <= packed_col[pc_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pk_wr) begin
      packed_value[VAW'(32'(pbase_q) + 32'(bk_q))] <= acc_rd;
    end
    pval_rd_q <= packed_value[pv_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rs_wr) begin
      row_start[next_row_q[RSAW-1:0]] <= cnt_q;
    end
    rs_rd_q <= row_start[rs_raddr];
  end

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_st_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign out_value_o   = out_val_q;
  assign out_index_o   = out_idx_q;
  assign block_count_o = out_cnt_q;

endmodule

@@ design/sparse_block_matrix_assembler_top.sv @@
// ----------------------------------------------------------------------------
// Sparse block matrix assembler
// Loads block triplets, builds block compressed rows and answers queries.
// ----------------------------------------------------------------------------
// Usage. Command words arrive on in_i and each gives exactly one result word
// on out_o; register writes (block rows, block columns in use) arrive on
// cfg_i and are always taken, but should only be sent while the block is idle.
// A command word is taken only in the idle state; one word is in flight at a
// time. A clear or an element load is decoded and loads its result, which the
// response state then pushes; a read entry or a read row start first reads its
// store. A load that starts a new block writes all its elements, one per cycle.
// The next command word is taken in the cycle after a result is pushed, so back
// to back clears pass through the idle, decode and response states in turn.
// Find walks the packed columns of one row, one per cycle, after two row start
// reads. Build reads the loaded store through its single port: an initial pass
// over all loaded elements, then for every distinct block a further pass over
// loaded_count times BLOCK_LEN squared elements, its packed write-out and its
// row start writes, and finally the remaining row starts.
// A result word sits in an output register, so the next command word may be
// taken while it waits; if the receiver stalls, the block finishes the next
// command and holds its result until the output register frees.
// Reset empties the load store, clears the built flag and restores the
// register defaults; no memory is cleared.
// ----------------------------------------------------------------------------
module sparse_block_matrix_assembler_top import sbma_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MaxBlocksDef,
  parameter int unsigned BLOCK_LEN  = BlockLenDef,
  parameter int unsigned MAX_ROWS   = MaxRowsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sbma_in_if.sink  in_i,
  sbma_out_if.source out_o,
  sbma_cfg_if.sink cfg_i
);

  cmd_t cmd;
  sts_t sts;

  // The controller owns the handshake on the command side; the datapath owns
  // the result register and the register write port.
  sbma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbma_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .BLOCK_LEN  (BLOCK_LEN),
    .MAX_ROWS   (MAX_ROWS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (in_i.kind),
    .row_index_i   (in_i.row_index),
    .col_index_i   (in_i.col_index),
    .element_i     (in_i.element),
    .value_i       (in_i.value),
    .position_i    (in_i.position),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .cfg_ready_o   (cfg_i.ready),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .status_o      (out_o.status),
    .out_row_o     (out_o.out_row),
    .out_col_o     (out_o.out_col),
    .out_value_o   (out_o.out_value),
    .out_index_o   (out_o.out_index),
    .block_count_o (out_o.block_count),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

@@ tb/sparse_block_matrix_assembler_top_test.sv @@
// ----------------------------------------------------------------------------
// Sparse block matrix assembler testbench
// Drives command words and register writes with random gaps and receiver
// stalls, predicts every result word from an in-bench model of the block,
// and compares each received result word field by field, oldest first.
// ----------------------------------------------------------------------------
module sparse_block_matrix_assembler_top_test;
  import sbma_pkg::*;

  localparam int unsigned MAX_BLK   = 256;
  localparam int unsigned BLK_SZ    = 4;   // two by two elements per block
  localparam int unsigned ROWS_MAX  = 64;
  localparam int unsigned WDOG_MAX  = 60000;
  localparam int unsigned END_WAIT  = 30;
  localparam int unsigned IDLE_WAIT = 12;
  localparam int unsigned ITEM_GOAL = 1850;

  // Kind codes that the block does not know; it must answer them out of range.
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

  typedef struct packed {
    status_e            st;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [VAL_W-1:0]   val;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   cnt;
  } result_word_t;

  logic clk_i;
  logic rst_ni;

  sbma_in_if  cmd_ch ();
  sbma_out_if res_ch ();
  sbma_cfg_if cfg_ch ();

  sparse_block_matrix_assembler_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // The clock runs with a period of ten units and starts low.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the stores, counters and registers.
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0] ld_row [MAX_BLK];
  logic [COL_W-1:0] ld_col [MAX_BLK];
  logic [VAL_W-1:0] ld_val [MAX_BLK*BLK_SZ];
  int unsigned      ld_cnt;
  logic [ROW_W-1:0] pk_row [MAX_BLK];
  logic [COL_W-1:0] pk_col [MAX_BLK];
  logic [VAL_W-1:0] pk_val [MAX_BLK*BLK_SZ];
  int unsigned      rs_tab [ROWS_MAX+1];
  int unsigned      pk_cnt;
  bit               is_built;
  int unsigned      cfg_rows;
  int unsigned      cfg_cols;

  result_word_t     pending_results [$];
  int unsigned      err_count;
  int unsigned      words_sent;
  int unsigned      hold_left;
  bit               quiet;

  function automatic int unsigned rows_in_use();
    return (cfg_rows > ROWS_MAX) ? ROWS_MAX : cfg_rows;
  endfunction

  function automatic int unsigned block_key(int unsigned p);
    return (int'(ld_row[p]) << COL_W) | int'(ld_col[p]);
  endfunction

  // Sorts the loaded blocks by position, drops those outside the registers,
  // sums blocks at the same position and rebuilds the row start table.
  function automatic void build_matrix();
    int unsigned ord [MAX_BLK];
    int unsigned nr, m, cnt, nxt, j, p;
    nr  = rows_in_use();
    m   = 0;
    cnt = 0;
    nxt = 0;
    for (int unsigned t = 0; t < ld_cnt; t++) begin
      if (ld_row[t] >= nr || ld_col[t] >= cfg_cols) continue;
      j = m;
      while (j > 0 && block_key(ord[j-1]) > block_key(t)) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = t;
      m++;
    end
    for (int unsigned t = 0; t < m; t++) begin
      p = ord[t];
      if (cnt > 0 && pk_row[cnt-1] == ld_row[p] && pk_col[cnt-1] == ld_col[p]) begin
        for (int unsigned k = 0; k < BLK_SZ; k++)
          pk_val[(cnt-1)*BLK_SZ+k] = pk_val[(cnt-1)*BLK_SZ+k] + ld_val[p*BLK_SZ+k];
      end else begin
        pk_row[cnt] = ld_row[p];
        pk_col[cnt] = ld_col[p];
        for (int unsigned k = 0; k < BLK_SZ; k++)
          pk_val[cnt*BLK_SZ+k] = ld_val[p*BLK_SZ+k];
        while (nxt <= ld_row[p] && nxt <= ROWS_MAX) begin
          rs_tab[nxt] = cnt;
          nxt++;
        end
        cnt++;
      end
    end
    while (nxt <= ROWS_MAX) begin
      rs_tab[nxt] = cnt;
      nxt++;
    end
    pk_cnt   = cnt;
    is_built = 1'b1;
  endfunction

  // Applies one command word to the predictor and returns its result word.
  function automatic result_word_t predict_result(logic [KIND_W-1:0] kind,
      logic [ROW_W-1:0] ri, logic [COL_W-1:0] ci, logic [EL_W-1:0] el,
      logic [VAL_W-1:0] val, logic [POS_W-1:0] pos);
    result_word_t r;
    int unsigned  hi;
    r    = '0;
    r.st = ST_OK;
    case (kind)
      KIND_CLEAR: ld_cnt = 0;
      KIND_LOAD: begin
        if (el == 0) begin
          if (ri >= rows_in_use() || ci >= cfg_cols) begin
            r.st = ST_RANGE;
          end else if (ld_cnt >= MAX_BLK) begin
            r.st = ST_FULL;
          end else begin
            ld_row[ld_cnt] = ri;
            ld_col[ld_cnt] = ci;
            for (int unsigned k = 1; k < BLK_SZ; k++) ld_val[ld_cnt*BLK_SZ+k] = '0;
            ld_val[ld_cnt*BLK_SZ] = val;
            ld_cnt++;
          end
        end else if (ld_cnt == 0) begin
          r.st = ST_RANGE;
        end else begin
          ld_val[(ld_cnt-1)*BLK_SZ+el] = val;
        end
      end
      KIND_BUILD: build_matrix();
      KIND_READ_ENTRY: begin
        if (!is_built) begin
          r.st = ST_NOT_BUILT;
        end else if (pos >= pk_cnt) begin
          r.st = ST_RANGE;
        end else begin
          r.row = pk_row[pos];
          r.col = pk_col[pos];
          r.val = pk_val[pos*BLK_SZ+el];
          r.idx = pos;
        end
      end
      KIND_READ_ROW: begin
        if (!is_built)          r.st = ST_NOT_BUILT;
        else if (pos > ROWS_MAX) r.st = ST_RANGE;
        else                     r.idx = IDX_W'(rs_tab[pos]);
      end
      KIND_FIND: begin
        if (!is_built) begin
          r.st = ST_NOT_BUILT;
        end else if (ri >= rows_in_use() || ci >= cfg_cols) begin
          r.st = ST_RANGE;
        end else begin
          r.st = ST_NOT_FOUND;
          hi   = rs_tab[ri+1];
          for (int unsigned p = rs_tab[ri]; p < hi; p++) begin
            if (pk_col[p] == ci) begin
              r.st  = ST_OK;
              r.idx = IDX_W'(p);
              break;
            end
          end
        end
      end
      default: r.st = ST_RANGE;
    endcase
    r.cnt = is_built ? IDX_W'(pk_cnt) : '0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side.
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one command word, waits for it to be taken and records its result.
  // The valid line is only lowered when a gap follows, so back to back words
  // keep it high without a second assignment in the same step.
  task automatic send_word(logic [KIND_W-1:0] kind, logic [ROW_W-1:0] ri,
      logic [COL_W-1:0] ci, logic [EL_W-1:0] el, logic [VAL_W-1:0] val,
      logic [POS_W-1:0] pos);
    int unsigned  gap;
    result_word_t want;
    cmd_ch.valid     <= 1'b1;
    cmd_ch.kind      <= kind;
    cmd_ch.row_index <= ri;
    cmd_ch.col_index <= ci;
    cmd_ch.element   <= el;
    cmd_ch.value     <= val;
    cmd_ch.position  <= pos;
    do @(posedge clk_i); while (!cmd_ch.ready);
    want            = predict_result(kind, ri, ci, el, val, pos);
    pending_results = {pending_results, want};
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_word(int unsigned ri, int unsigned ci, int unsigned el,
      logic [VAL_W-1:0] val);
    send_word(KIND_LOAD, ri, ci, el, val, $urandom);
  endtask

  // Queries and bare commands; the fields that the kind ignores carry noise.
  task automatic query_word(logic [KIND_W-1:0] kind, int unsigned ri,
      int unsigned ci, int unsigned el, int unsigned pos);
    send_word(kind, ri, ci, el, $urandom, pos);
  endtask

  task automatic bare_word(logic [KIND_W-1:0] kind);
    send_word(kind, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Waits until every result word has come back, then lets the block settle.
  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
  endtask

  // Register writes are only made while the block is idle.
  task automatic write_reg(cfg_reg_e idx, logic [NC_W-1:0] data);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    if (idx == CFG_NUM_ROWS) cfg_rows = data[NR_W-1:0];
    else                     cfg_cols = data;
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random stalls, plus a long hold-off on request.
  // --------------------------------------------------------------------------
  int unsigned stall_left;

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      res_ch.ready <= 1'b1;
      if (!quiet) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: stall_left = $urandom_range(1, 3);
          4:          stall_left = $urandom_range(8, 30);
          default:    stall_left = 0;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checking of every result word against the oldest expectation.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
             want);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    result_word_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("[%0t] result word with nothing expected", $realtime);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_ch.status != want.st) report_mismatch("status", res_ch.status, want.st);
        if (res_ch.out_row != want.row) report_mismatch("out_row", res_ch.out_row, want.row);
        if (res_ch.out_col != want.col) report_mismatch("out_col", res_ch.out_col, want.col);
        if (res_ch.out_value != want.val)
          report_mismatch("out_value", res_ch.out_value, want.val);
        if (res_ch.out_index != want.idx)
          report_mismatch("out_index", res_ch.out_index, want.idx);
        if (res_ch.block_count != want.cnt)
          report_mismatch("block_count", res_ch.block_count, want.cnt);
      end
    end
  end

  // The watchdog counts cycles in which no channel moves a word; a build of
  // the larger sets used here stays far below the limit.
  int unsigned still_cycles;

  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      still_cycles = 0;
    end else begin
      still_cycles++;
      if (still_cycles >= WDOG_MAX) begin
        $display("watchdog expired with %0d results outstanding", pending_results.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Queries before any build, unknown kinds, element writes with no block,
  // range checks at the register extremes and the value extremes.
  task automatic test_directed();
    query_word(KIND_READ_ENTRY, 0, 0, 0, 0);
    query_word(KIND_READ_ROW, 0, 0, 0, 0);
    query_word(KIND_FIND, 0, 0, 0, 0);
    bare_word(KIND_SPARE_A);
    bare_word(KIND_SPARE_B);
    load_word(0, 0, 3, 32'h1234_5678);
    bare_word(KIND_BUILD);
    query_word(KIND_READ_ENTRY, 0, 0, 0, 0);
    write_reg(CFG_NUM_ROWS, 1);
    write_reg(CFG_NUM_COLS, 1);
    load_word(1, 0, 0, 32'h1);
    load_word(0, 1, 0, 32'h1);
    load_word(0, 0, 0, 32'h8000_0000);
    load_word(0, 0, 1, 32'h7FFF_FFFF);
    load_word(0, 0, 3, 32'hFFFF_FFFF);
    load_word(0, 0, 0, 32'h8000_0000);
    bare_word(KIND_BUILD);
    for (int unsigned e = 0; e < BLK_SZ; e++) query_word(KIND_READ_ENTRY, 0, 0, e, 0);
    query_word(KIND_READ_ENTRY, 0, 0, 0, 1);
    query_word(KIND_READ_ENTRY, 0, 0, 0, 511);
    query_word(KIND_READ_ROW, 0, 0, 0, 1);
    query_word(KIND_READ_ROW, 0, 0, 0, ROWS_MAX);
    query_word(KIND_READ_ROW, 0, 0, 0, ROWS_MAX + 1);
    query_word(KIND_FIND, 0, 0, 0, 0);
    query_word(KIND_FIND, 1, 0, 0, 0);
    query_word(KIND_FIND, 0, 1, 0, 0);
    bare_word(KIND_CLEAR);
    query_word(KIND_READ_ENTRY, 0, 0, 2, 0);
    write_reg(CFG_NUM_ROWS, 127);
    write_reg(CFG_NUM_COLS, 2047);
    load_word(63, 1023, 0, 32'h5555_AAAA);
    query_word(KIND_FIND, 63, 1023, 0, 0);
    bare_word(KIND_BUILD);
    query_word(KIND_FIND, 63, 1023, 0, 0);
    write_reg(CFG_NUM_ROWS, 0);
    write_reg(CFG_NUM_COLS, 0);
    load_word(0, 0, 0, 32'h1);
    query_word(KIND_FIND, 0, 0, 0, 0);
    bare_word(KIND_BUILD);
    query_word(KIND_READ_ROW, 0, 0, 0, 0);
  endtask

  // Fills the load store with blocks at four positions only, so that the
  // build stays short, then overflows it and builds.
  task automatic test_store_full();
    write_reg(CFG_NUM_ROWS, 64);
    write_reg(CFG_NUM_COLS, 1024);
    bare_word(KIND_CLEAR);
    for (int unsigned b = 0; b < MAX_BLK; b++)
      load_word($urandom_range(0, 1), $urandom_range(0, 1), 0, $urandom);
    load_word(0, 0, 0, 32'h1);
    load_word(0, 0, 2, 32'hDEAD_BEEF);
    bare_word(KIND_BUILD);
    for (int unsigned p = 0; p < 5; p++) query_word(KIND_READ_ENTRY, 0, 0, p & 3, p);
    bare_word(KIND_CLEAR);
  endtask

  // Loads a set of blocks, mostly at a small pool of positions so that
  // duplicates are summed, builds it and queries the result.
  task automatic run_random_set(int unsigned nblk);
    int unsigned ri, ci, pos;
    int unsigned rlim, clim;
    rlim = rows_in_use() > 0 ? rows_in_use() - 1 : 0;
    clim = cfg_cols > 0 ? ((cfg_cols > 1024) ? 1023 : cfg_cols - 1) : 0;
    if ($urandom_range(0, 4) != 0 || ld_cnt > 40) bare_word(KIND_CLEAR);
    for (int unsigned b = 0; b < nblk; b++) begin
      if ($urandom_range(0, 3) == 0) begin
        ri = $urandom_range(0, rlim);
        ci = $urandom_range(0, clim);
      end else begin
        ri = $urandom_range(0, rlim < 3 ? rlim : 3);
        ci = $urandom_range(0, clim < 3 ? clim : 3);
      end
      // Now and then an out of range block or a noise word is mixed in.
      if ($urandom_range(0, 9) == 0) ri = $urandom_range(0, 63);
      if ($urandom_range(0, 9) == 0) ci = $urandom_range(0, 1023);
      load_word(ri, ci, 0, $urandom);
      for (int unsigned e = 1; e < BLK_SZ; e++)
        if ($urandom_range(0, 2) != 0) load_word(ri, ci, e, $urandom);
      if ($urandom_range(0, 14) == 0) bare_word($urandom_range(KIND_READ_ENTRY, 7));
    end
    bare_word(KIND_BUILD);
    repeat ($urandom_range(6, 16)) begin
      case ($urandom_range(0, 2))
        0: begin
          pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                             : $urandom_range(0, pk_cnt + 1);
          query_word(KIND_READ_ENTRY, 0, 0, $urandom_range(0, 3), pos);
        end
        1: begin
          pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                             : $urandom_range(0, ROWS_MAX + 1);
          query_word(KIND_READ_ROW, 0, 0, 0, pos);
        end
        default: begin
          if (pk_cnt > 0 && $urandom_range(0, 1) == 0) begin
            pos = $urandom_range(0, pk_cnt - 1);
            query_word(KIND_FIND, pk_row[pos], pk_col[pos], 0, 0);
          end else begin
            query_word(KIND_FIND, $urandom_range(0, rlim < 4 ? rlim : 4),
                       $urandom_range(0, clim < 4 ? clim : 4), 0, 0);
          end
        end
      endcase
    end
  endtask

  // Random sets under changing registers, with occasional quiet stretches
  // in which neither side idles.
  task automatic test_random_sets();
    while (words_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 5))
          0:       write_reg(CFG_NUM_ROWS, 64);
          1:       write_reg(CFG_NUM_ROWS, $urandom_range(1, 8));
          2:       write_reg(CFG_NUM_ROWS, $urandom_range(0, 2047));
          3:       write_reg(CFG_NUM_COLS, 1024);
          4:       write_reg(CFG_NUM_COLS, $urandom_range(1, 8));
          default: write_reg(CFG_NUM_COLS, $urandom_range(0, 2047));
        endcase
      end
      quiet = ($urandom_range(0, 7) == 0);
      run_random_set($urandom_range(1, 12));
    end
    quiet = 1'b0;
  endtask

  // The receiver holds off for a long stretch while words keep coming, so
  // the output register fills and the input stalls.
  task automatic test_backpressure();
    write_reg(CFG_NUM_ROWS, 64);
    write_reg(CFG_NUM_COLS, 1024);
    hold_left = 300;
    bare_word(KIND_CLEAR);
    for (int unsigned b = 0; b < 6; b++) load_word(b & 1, b & 2, 0, $urandom);
    bare_word(KIND_BUILD);
    for (int unsigned p = 0; p < 8; p++) query_word(KIND_READ_ENTRY, 0, 0, p & 3, p & 3);
  endtask

  initial begin
    rst_ni           = 1'b0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.kind      = KIND_CLEAR;
    cmd_ch.row_index = '0;
    cmd_ch.col_index = '0;
    cmd_ch.element   = '0;
    cmd_ch.value     = '0;
    cmd_ch.position  = '0;
    res_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_NUM_ROWS;
    cfg_ch.data      = '0;
    ld_cnt           = 0;
    pk_cnt           = 0;
    is_built         = 1'b0;
    cfg_rows         = 64;
    cfg_cols         = 1024;
    err_count        = 0;
    words_sent       = 0;
    hold_left        = 0;
    stall_left       = 0;
    still_cycles     = 0;
    quiet            = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_store_full();
    test_backpressure();
    test_random_sets();

    wait_idle();
    repeat (END_WAIT) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/sbma_pkg.sv
design/sbma_if.sv
design/sbma_ctrl.sv
design/sbma_dp.sv
design/sparse_block_matrix_assembler_top.sv
tb/sparse_block_matrix_assembler_top_test.sv
